/* hdl/nlt_pkg.sv */
package nlt_pkg;

    localparam int NODE_BITS  = 12;
    localparam int NODE_COUNT = 1 << NODE_BITS;
    localparam int SLOT_BITS  = 3;
    localparam int MAX_LINKS  = 1 << SLOT_BITS;
    localparam int COORD_BITS = 24;
    localparam int DIST_BITS  = 25;
    localparam int FILL_BITS  = 4;
    localparam int SQ_BITS    = 2 * DIST_BITS;

    localparam logic [FILL_BITS-1:0] LINKS_KEPT_RESET = 4'd8;

    // register indexes
    localparam logic REG_LINKS_KEPT = 1'b0;

    // item functions
    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // row actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_ADDED    = 2'd1;
    localparam logic [1:0] ACT_REPLACED = 2'd2;
    localparam logic [1:0] ACT_UPDATED  = 2'd3;

    typedef struct packed {
        logic                         func;
        logic [NODE_BITS-1:0]         node_a;
        logic [NODE_BITS-1:0]         node_b;
        logic signed [COORD_BITS-1:0] x_a;
        logic signed [COORD_BITS-1:0] y_a;
        logic signed [COORD_BITS-1:0] x_b;
        logic signed [COORD_BITS-1:0] y_b;
        logic                         weight_positive;
        logic [SLOT_BITS-1:0]         slot;
    } nlt_in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic [1:0]           action_a;
        logic [1:0]           action_b;
        logic                 slot_valid;
        logic [NODE_BITS-1:0] neighbor;
        logic [FILL_BITS-1:0] row_count;
        logic [DIST_BITS-1:0] min_distance;
    } nlt_out_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] nb;
        logic [DIST_BITS-1:0] link_dist;
    } nlt_link_t;

    typedef struct packed {
        logic [FILL_BITS-1:0] fill;
        logic [DIST_BITS-1:0] min_dist;
    } nlt_node_t;

    typedef struct packed {
        logic [FILL_BITS-1:0] links_kept;
    } nlt_cfg_t;

endpackage

/* hdl/nlt_apb_regs.sv */
module nlt_apb_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output nlt_pkg::nlt_cfg_t    cfg
);

    logic [nlt_pkg::FILL_BITS-1:0] links_kept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            links_kept_reg <= nlt_pkg::LINKS_KEPT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == nlt_pkg::REG_LINKS_KEPT))
        begin
            links_kept_reg <= pwdata[nlt_pkg::FILL_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == nlt_pkg::REG_LINKS_KEPT)
        begin
            prdata = {{(32 - nlt_pkg::FILL_BITS){1'b0}}, links_kept_reg};
        end
    end

    assign pready         = 1'b1;
    assign cfg.links_kept = links_kept_reg;

endmodule

/* hdl/nlt_dist.sv */
module nlt_dist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [nlt_pkg::COORD_BITS-1:0] x_a,
    input  logic signed [nlt_pkg::COORD_BITS-1:0] y_a,
    input  logic signed [nlt_pkg::COORD_BITS-1:0] x_b,
    input  logic signed [nlt_pkg::COORD_BITS-1:0] y_b,
    output logic                                 done,
    output logic [nlt_pkg::DIST_BITS-1:0]        root
);

    localparam int DB = nlt_pkg::DIST_BITS;
    localparam int SB = nlt_pkg::SQ_BITS;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_SQ   = 4'b0010,
        D_SUM  = 4'b0100,
        D_ROOT = 4'b1000
    } dist_state_t;

    dist_state_t      state_reg;
    logic [DB-1:0]    dx_reg, dy_reg;
    logic [SB-1:0]    sqx_reg, sqy_reg;
    logic [SB-1:0]    v_reg, res_reg, bit_reg;
    logic             done_reg;
    logic [DB-1:0]    dist_reg;
    logic signed [DB-1:0] diff_x, diff_y;
    logic [SB-1:0]    trial;
    logic [SB-1:0]    v_next, res_next;

    assign diff_x = {x_a[nlt_pkg::COORD_BITS-1], x_a} - {x_b[nlt_pkg::COORD_BITS-1], x_b};
    assign diff_y = {y_a[nlt_pkg::COORD_BITS-1], y_a} - {y_b[nlt_pkg::COORD_BITS-1], y_b};

    // one result bit per cycle, two radicand bits
    always_comb
    begin
        trial = res_reg + bit_reg;
        if (v_reg >= trial)
        begin
            v_next   = v_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            v_next   = v_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_SQ;
                    end
                end
                D_SQ:
                begin
                    state_reg <= D_SUM;
                end
                D_SUM:
                begin
                    state_reg <= D_ROOT;
                end
                D_ROOT:
                begin
                    if (bit_reg == {{(SB-1){1'b0}}, 1'b1})
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            dx_reg <= diff_x[DB-1] ? DB'(-diff_x) : DB'(diff_x);
            dy_reg <= diff_y[DB-1] ? DB'(-diff_y) : DB'(diff_y);
        end
        if (state_reg == D_SQ)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
        if (state_reg == D_SUM)
        begin
            v_reg   <= sqx_reg + sqy_reg;
            res_reg <= '0;
            bit_reg <= {2'b01, {(SB-2){1'b0}}};
        end
        if (state_reg == D_ROOT)
        begin
            v_reg    <= v_next;
            res_reg  <= res_next;
            bit_reg  <= bit_reg >> 2;
            dist_reg <= res_next[DB-1:0];
        end
    end

    assign done = done_reg;
    assign root = dist_reg;

endmodule

/* hdl/nearest_link_table_unit.sv */
// nearest link table: keeps, for every node, up to links_kept shortest
// links offered to it, plus the node's minimum distance (0 means unset).
// an offer transfer computes floor(sqrt(dx*dx + dy*dy)) with an iterative
// root (one result bit per cycle); flagged offers then update row a and
// row b in turn, each taking a node word read, one link memory read per
// held slot and one write-back. one item is in flight at a time. after
// reset a clearing pass zeroes the node memory; no input transfer is taken
// meanwhile. link slots are never cleared: only slots below a row's fill
// are used.
module nearest_link_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  nlt_pkg::nlt_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output nlt_pkg::nlt_out_t   out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NB = nlt_pkg::NODE_BITS;
    localparam int SL = nlt_pkg::SLOT_BITS;
    localparam int FB = nlt_pkg::FILL_BITS;
    localparam int DB = nlt_pkg::DIST_BITS;
    localparam logic [FB-1:0] MAX_FILL = FB'(nlt_pkg::MAX_LINKS);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_Q_RD   = 10'b0000000100,
        ST_Q_DATA = 10'b0000001000,
        ST_DIST   = 10'b0000010000,
        ST_N_RD   = 10'b0000100000,
        ST_N_DATA = 10'b0001000000,
        ST_SCAN   = 10'b0010000000,
        ST_DECIDE = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } nlt_state_t;

    nlt_pkg::nlt_cfg_t cfg;

    nlt_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nlt_state_t        state_reg, state_next;
    nlt_pkg::nlt_in_t  item_reg;
    logic [NB-1:0]     clr_idx_reg;
    logic              side_reg;
    logic [DB-1:0]     dist_reg;
    logic [1:0]        act_a_reg, act_b_reg;
    logic [FB-1:0]     fill_reg;
    logic [DB-1:0]     min_reg;
    logic [FB-1:0]     issue_reg;
    logic              pend_reg;
    logic [SL-1:0]     pend_idx_reg;
    logic              found_reg;
    logic [SL-1:0]     match_reg;
    logic              any_reg;
    logic [DB-1:0]     big_reg;
    logic [SL-1:0]     big_slot_reg;
    logic              out_valid_reg;
    nlt_pkg::nlt_out_t out_reg;
    nlt_pkg::nlt_out_t out_next;

    // node memory: fill count and minimum distance per node
    nlt_pkg::nlt_node_t node_mem [nlt_pkg::NODE_COUNT];
    nlt_pkg::nlt_node_t node_q;
    logic               node_re, node_we;
    logic [NB-1:0]      node_raddr, node_waddr;
    nlt_pkg::nlt_node_t node_wdata;

    // link memory: one row of slots per node
    nlt_pkg::nlt_link_t link_mem [nlt_pkg::NODE_COUNT * nlt_pkg::MAX_LINKS];
    nlt_pkg::nlt_link_t link_q;
    logic               link_re, link_we;
    logic [NB+SL-1:0]   link_raddr, link_waddr;
    nlt_pkg::nlt_link_t link_wdata;

    logic              dist_start, dist_done;
    logic [DB-1:0]     dist_val;

    logic              accept;
    logic [NB-1:0]     cur_node, cur_nb;
    logic [FB-1:0]     limit;
    logic [1:0]        act;
    logic [DB-1:0]     min_low;
    logic              out_load;

    nlt_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .x_a   (item_reg.x_a),
        .y_a   (item_reg.y_a),
        .x_b   (item_reg.x_b),
        .y_b   (item_reg.y_b),
        .done  (dist_done),
        .root  (dist_val)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign cur_node = side_reg ? item_reg.node_b : item_reg.node_a;
    assign cur_nb   = side_reg ? item_reg.node_a : item_reg.node_b;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // effective limit: zero acts as one, clamp at the row size
    always_comb
    begin
        if (cfg.links_kept == '0)
        begin
            limit = FB'(1);
        end
        else if (cfg.links_kept > MAX_FILL)
        begin
            limit = MAX_FILL;
        end
        else
        begin
            limit = cfg.links_kept;
        end
    end

    assign min_low = (node_q.min_dist == '0 || node_q.min_dist > dist_reg) ?
                     dist_reg : node_q.min_dist;

    // row decision: update in place, append, replace largest, or nothing
    always_comb
    begin
        act = nlt_pkg::ACT_NONE;
        if (found_reg)
        begin
            act = nlt_pkg::ACT_UPDATED;
        end
        else if (fill_reg < limit)
        begin
            act = nlt_pkg::ACT_ADDED;
        end
        else if (any_reg && dist_reg < big_reg)
        begin
            act = nlt_pkg::ACT_REPLACED;
        end
    end

    // memory port control
    always_comb
    begin
        node_re    = 1'b0;
        node_raddr = cur_node;
        node_we    = 1'b0;
        node_waddr = cur_node;
        node_wdata = '{fill: fill_reg, min_dist: min_reg};
        link_re    = 1'b0;
        link_raddr = {cur_node, issue_reg[SL-1:0]};
        link_we    = 1'b0;
        link_waddr = {cur_node, fill_reg[SL-1:0]};
        link_wdata = '{nb: cur_nb, link_dist: dist_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_idx_reg;
                node_wdata = '0;
            end
            ST_Q_RD:
            begin
                node_re    = 1'b1;
                node_raddr = item_reg.node_a;
                link_re    = 1'b1;
                link_raddr = {item_reg.node_a, item_reg.slot};
            end
            ST_N_RD:
            begin
                node_re = 1'b1;
            end
            ST_SCAN:
            begin
                link_re = (issue_reg < fill_reg);
            end
            ST_DECIDE:
            begin
                node_we = 1'b1;
                if (act == nlt_pkg::ACT_ADDED)
                begin
                    node_wdata.fill = fill_reg + FB'(1);
                end
                case (act)
                    nlt_pkg::ACT_UPDATED:
                    begin
                        link_we    = 1'b1;
                        link_waddr = {cur_node, match_reg};
                    end
                    nlt_pkg::ACT_ADDED:
                    begin
                        link_we = 1'b1;
                    end
                    nlt_pkg::ACT_REPLACED:
                    begin
                        link_we    = 1'b1;
                        link_waddr = {cur_node, big_slot_reg};
                    end
                    default:
                    begin
                        link_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                node_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_re)
        begin
            node_q <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_re)
        begin
            link_q <= link_mem[link_raddr];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        dist_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == {NB{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_data.func == nlt_pkg::FUNC_QUERY) ? ST_Q_RD : ST_DIST;
                end
            end
            ST_Q_RD:
            begin
                state_next = ST_Q_DATA;
            end
            ST_Q_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_DIST:
            begin
                // no start on the done cycle, the root unit is idle again then
                dist_start = !dist_done;
                if (dist_done)
                begin
                    state_next = item_reg.weight_positive ? ST_N_RD : ST_DONE;
                end
            end
            ST_N_RD:
            begin
                state_next = ST_N_DATA;
            end
            ST_N_DATA:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!(issue_reg < fill_reg) && !pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = side_reg ? ST_DONE : ST_N_RD;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + NB'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= in_data;
            side_reg  <= 1'b0;
            act_a_reg <= nlt_pkg::ACT_NONE;
            act_b_reg <= nlt_pkg::ACT_NONE;
            dist_reg  <= '0;
        end
        if (state_reg == ST_DIST && dist_done)
        begin
            dist_reg <= dist_val;
        end
        if (state_reg == ST_Q_DATA)
        begin
            fill_reg <= node_q.fill;
            min_reg  <= node_q.min_dist;
            if (FB'(item_reg.slot) < node_q.fill)
            begin
                found_reg <= 1'b1;
                dist_reg  <= link_q.link_dist;
                match_reg <= item_reg.slot;
            end
            else
            begin
                found_reg <= 1'b0;
                dist_reg  <= '0;
            end
            big_slot_reg <= '0;
            big_reg      <= '0;
            any_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            issue_reg    <= '0;
            pend_idx_reg <= '0;
        end
        if (state_reg == ST_N_DATA)
        begin
            fill_reg  <= (node_q.fill > MAX_FILL) ? MAX_FILL : node_q.fill;
            min_reg   <= min_low;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (issue_reg < fill_reg)
            begin
                issue_reg    <= issue_reg + FB'(1);
                pend_idx_reg <= issue_reg[SL-1:0];
                pend_reg     <= 1'b1;
            end
            else
            begin
                pend_reg <= 1'b0;
            end
            if (pend_reg)
            begin
                if (!found_reg && link_q.nb == cur_nb)
                begin
                    found_reg <= 1'b1;
                    match_reg <= pend_idx_reg;
                end
                if (!any_reg || link_q.link_dist > big_reg)
                begin
                    any_reg      <= 1'b1;
                    big_reg      <= link_q.link_dist;
                    big_slot_reg <= pend_idx_reg;
                end
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            side_reg <= 1'b1;
            if (side_reg)
            begin
                act_b_reg <= act;
            end
            else
            begin
                act_a_reg <= act;
            end
        end
    end

    // result word for the finished item
    always_comb
    begin
        out_next = '0;
        out_next.distance = dist_reg;
        if (item_reg.func == nlt_pkg::FUNC_QUERY)
        begin
            out_next.slot_valid   = found_reg;
            out_next.neighbor     = found_reg ? link_q.nb : '0;
            out_next.row_count    = fill_reg;
            out_next.min_distance = min_reg;
        end
        else
        begin
            out_next.action_a = act_a_reg;
            out_next.action_b = act_b_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
